FILE: design/blk3_pkg.sv
package blk3_pkg;

    localparam logic [6:0] FLAG_START  = 7'd1;
    localparam logic [6:0] FLAG_END    = 7'd2;
    localparam logic [6:0] FLAG_PARENT = 7'd4;
    localparam logic [6:0] FLAG_ROOT   = 7'd8;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_CV    = 2'd1;
    localparam logic [1:0] KIND_MSG   = 2'd2;

    localparam logic [31:0] BLK_IV [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [3:0] MSG_PERM [16] = '{
        4'd2, 4'd6, 4'd3, 4'd10, 4'd7, 4'd0, 4'd4, 4'd13,
        4'd1, 4'd11, 4'd12, 4'd5, 4'd9, 4'd14, 4'd15, 4'd8
    };

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_COMP = 4'b0010,
        ST_FIN  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    typedef logic [31:0] word_t;

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

FILE: design/blake3_chunk_compressor.sv
// one message word or chaining word per cycle while idle; start items are single transfers
// a full block costs 16 word transfers plus seven rounds of 16 half-mixes
// on one shared half-mix unit and then a finalize step
// after the last block, 8 or 16 result words leave one per transfer; no input meanwhile
// rst_n is asynchronous active low: idle, no job, wide_output cleared, chain value = IV
module blake3_chunk_compressor #(
    parameter int CHUNK_BYTES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [31:0] data_word,
    input  logic [63:0] counter,
    input  logic [6:0]  flags,
    input  logic [10:0] length,
    input  logic        cv_given,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] hash_word,
    output logic        last
);
    import blk3_pkg::*;

    localparam logic [10:0] CHUNK_LEN = 11'(CHUNK_BYTES);

    // control state
    state_t      state_reg, state_next;
    logic        wide_reg;
    logic        job_wide_reg;
    logic        active_reg;
    logic        had_cv_reg;
    logic [3:0]  cv_count_reg;
    logic [3:0]  block_idx_reg;
    logic [3:0]  word_idx_reg;
    logic [3:0]  step_reg;      // half-mix step within a round
    logic [2:0]  round_reg;
    logic [3:0]  out_idx_reg;
    logic        last_blk_reg;

    // job payload
    logic [63:0] job_counter_reg;
    logic [6:0]  job_flags_reg;
    logic [10:0] job_length_reg;
    word_t       cv_reg [8];
    word_t       upper_reg [8];
    word_t       msg_reg [16];
    word_t       v_reg [16];

    logic        in_xfer;
    logic        out_xfer;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign in_xfer   = in_valid && in_ready;
    assign out_xfer  = out_valid && out_ready;

    // ---------------- message word masking and block parameters ----------------
    logic [10:0] blk_off;
    logic [10:0] word_pos;
    logic [10:0] nb;
    word_t       masked_word;
    logic [11:0] nblocks_raw;
    logic [4:0]  nblocks;
    logic        is_last_blk;
    logic [10:0] blen_raw;
    logic [6:0]  blen;
    logic [6:0]  blk_flags;
    logic [10:0] sat_len;

    assign blk_off  = {1'b0, block_idx_reg, 6'd0};
    assign word_pos = blk_off + {5'd0, word_idx_reg, 2'd0};
    assign nb       = (job_length_reg > word_pos) ? (job_length_reg - word_pos) : 11'd0;

    always_comb
    begin
        case (nb)
            11'd0:   masked_word = 32'd0;
            11'd1:   masked_word = {24'd0, data_word[7:0]};
            11'd2:   masked_word = {16'd0, data_word[15:0]};
            11'd3:   masked_word = {8'd0, data_word[23:0]};
            default: masked_word = data_word;
        endcase
    end

    assign nblocks_raw = ({1'b0, job_length_reg} + 12'd63) >> 6;
    assign nblocks     = (nblocks_raw == 12'd0) ? 5'd1 : nblocks_raw[4:0];
    assign is_last_blk = ({1'b0, block_idx_reg} + 5'd1) >= nblocks;
    assign blen_raw    = (job_length_reg > blk_off) ? (job_length_reg - blk_off) : 11'd0;
    assign blen        = (blen_raw > 11'd64) ? 7'd64 : blen_raw[6:0];

    always_comb
    begin
        blk_flags = job_flags_reg;
        if (!is_last_blk)
        begin
            blk_flags = blk_flags & ~FLAG_ROOT;
        end
        if (!job_wide_reg && ((blk_flags & FLAG_PARENT) == 7'd0))
        begin
            if ((block_idx_reg == 4'd0) && !had_cv_reg)
            begin
                blk_flags = blk_flags | FLAG_START;
            end
            if (is_last_blk)
            begin
                blk_flags = blk_flags | FLAG_END;
            end
        end
    end

    assign sat_len = (length > CHUNK_LEN) ? CHUNK_LEN : length;

    // ---------------- shared half-mix unit ----------------
    // the vector rotates its rows after every full mix, so the unit always
    // works on fixed positions: a column (0,4,8,12) or a diagonal (0,5,10,15)
    logic  diag;
    logic  second_half;
    word_t ga, gb, gc, gd, gx;
    word_t a1, b1, c1, d1;
    word_t v_upd [16];
    word_t v_next [16];
    word_t m_shift [16];
    word_t m_next [16];

    assign diag        = step_reg[3];
    assign second_half = step_reg[0];
    assign ga = v_reg[0];
    assign gb = diag ? v_reg[5]  : v_reg[4];
    assign gc = diag ? v_reg[10] : v_reg[8];
    assign gd = diag ? v_reg[15] : v_reg[12];
    assign gx = msg_reg[0];

    assign a1 = ga + gb + gx;
    assign d1 = rotr(gd ^ a1, second_half ? 8 : 16);
    assign c1 = gc + d1;
    assign b1 = rotr(gb ^ c1, second_half ? 7 : 12);

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            v_upd[i] = v_reg[i];
        end
        v_upd[0] = a1;
        if (diag)
        begin
            v_upd[5]  = b1;
            v_upd[10] = c1;
            v_upd[15] = d1;
        end
        else
        begin
            v_upd[4]  = b1;
            v_upd[8]  = c1;
            v_upd[12] = d1;
        end
        for (int r = 0; r < 4; r++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                v_next[4 * r + j] = second_half ? v_upd[4 * r + ((j + 1) % 4)]
                                                : v_upd[4 * r + j];
            end
        end
    end

    // message words stream past position 0; after a full round they are back
    // in order and get the round permutation
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            m_shift[i] = msg_reg[(i + 1) % 16];
        end
        for (int i = 0; i < 16; i++)
        begin
            m_next[i] = (step_reg == 4'd15) ? m_shift[MSG_PERM[i]] : m_shift[i];
        end
    end

    // ---------------- sequencer ----------------
    logic [3:0] n_out_last;
    assign n_out_last = job_wide_reg ? 4'd15 : 4'd7;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (kind == KIND_MSG) && active_reg && (word_idx_reg == 4'd15))
                begin
                    state_next = ST_COMP;
                end
            end
            ST_COMP:
            begin
                if ((step_reg == 4'd15) && (round_reg == 3'd6))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                state_next = last_blk_reg ? ST_OUT : ST_IDLE;
            end
            ST_OUT:
            begin
                if (out_xfer && (out_idx_reg == n_out_last))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            wide_reg        <= 1'b0;
            job_wide_reg    <= 1'b0;
            active_reg      <= 1'b0;
            had_cv_reg      <= 1'b0;
            cv_count_reg    <= 4'd0;
            block_idx_reg   <= 4'd0;
            word_idx_reg    <= 4'd0;
            step_reg        <= 4'd0;
            round_reg       <= 3'd0;
            out_idx_reg     <= 4'd0;
            last_blk_reg    <= 1'b0;
            job_counter_reg <= 64'd0;
            job_flags_reg   <= 7'd0;
            job_length_reg  <= 11'd0;
            for (int i = 0; i < 8; i++)
            begin
                cv_reg[i]    <= BLK_IV[i];
                upper_reg[i] <= 32'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                wide_reg <= cfg_wdata;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if (kind == KIND_START)
                        begin
                            job_counter_reg <= counter;
                            job_flags_reg   <= flags;
                            job_length_reg  <= sat_len;
                            had_cv_reg      <= cv_given;
                            job_wide_reg    <= wide_reg;
                            block_idx_reg   <= 4'd0;
                            word_idx_reg    <= 4'd0;
                            cv_count_reg    <= 4'd0;
                            active_reg      <= 1'b1;
                            for (int i = 0; i < 8; i++)
                            begin
                                cv_reg[i] <= BLK_IV[i];
                            end
                        end
                        else if (kind == KIND_CV)
                        begin
                            if (active_reg && had_cv_reg && !cv_count_reg[3]
                                && (block_idx_reg == 4'd0) && (word_idx_reg == 4'd0))
                            begin
                                cv_reg[cv_count_reg[2:0]] <= data_word;
                                cv_count_reg <= cv_count_reg + 4'd1;
                            end
                        end
                        else if ((kind == KIND_MSG) && active_reg)
                        begin
                            word_idx_reg <= word_idx_reg + 4'd1;
                            if (word_idx_reg == 4'd15)
                            begin
                                last_blk_reg <= is_last_blk;
                                step_reg     <= 4'd0;
                                round_reg    <= 3'd0;
                            end
                        end
                    end
                end
                ST_COMP:
                begin
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'd15)
                    begin
                        round_reg <= round_reg + 3'd1;
                    end
                end
                ST_FIN:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        cv_reg[i] <= v_reg[i] ^ v_reg[8 + i];
                        if (job_wide_reg)
                        begin
                            upper_reg[i] <= v_reg[8 + i] ^ cv_reg[i];
                        end
                    end
                    out_idx_reg <= 4'd0;
                    if (last_blk_reg)
                    begin
                        active_reg <= 1'b0;
                    end
                    else
                    begin
                        block_idx_reg <= block_idx_reg + 4'd1;
                    end
                end
                ST_OUT:
                begin
                    if (out_xfer)
                    begin
                        out_idx_reg <= out_idx_reg + 4'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // message buffer and work vector carry no reset
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && in_xfer && (kind == KIND_MSG) && active_reg)
        begin
            msg_reg[word_idx_reg] <= masked_word;
            if (word_idx_reg == 4'd15)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    v_reg[i] <= cv_reg[i];
                end
                for (int i = 0; i < 4; i++)
                begin
                    v_reg[8 + i] <= BLK_IV[i];
                end
                v_reg[12] <= job_counter_reg[31:0];
                v_reg[13] <= job_counter_reg[63:32];
                v_reg[14] <= {25'd0, blen};
                v_reg[15] <= {25'd0, blk_flags};
            end
        end
        else if (state_reg == ST_COMP)
        begin
            for (int i = 0; i < 16; i++)
            begin
                v_reg[i]   <= v_next[i];
                msg_reg[i] <= m_next[i];
            end
        end
    end

    // result words: chain value first, then the upper half in wide mode
    assign hash_word = out_idx_reg[3] ? upper_reg[out_idx_reg[2:0]] : cv_reg[out_idx_reg[2:0]];
    assign last      = (out_idx_reg == n_out_last);

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last) |=> in_ready)
        else $error("output end did not return to idle");

    a_block_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (kind == KIND_MSG) && active_reg && (word_idx_reg == 4'd15))
        |=> (state_reg == ST_COMP) && (step_reg == 4'd0) && (round_reg == 3'd0))
        else $error("full block did not start compression");

    a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMP) |-> (round_reg <= 3'd6))
        else $error("round count overran");

    a_out_job_closed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !active_reg && (out_idx_reg <= n_out_last))
        else $error("output while job still open");
`endif

endmodule
